### rtl/cfi_pkg.sv
package cfi_pkg;

	// table capacity
	localparam int MAX_BLOCKS = 256;
	localparam int MAX_EDGES  = 1024;

	localparam int BLK_AW  = $clog2(MAX_BLOCKS);
	localparam int BCNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int EDGE_AW = $clog2(MAX_EDGES);
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);

	// block entry: {id, first edge, edge total}
	localparam int BLK_W = 32 + EDGE_AW + ECNT_W;

	typedef logic [1:0] cmd_code_t;
	localparam cmd_code_t CMD_CLEAR  = 2'd0;
	localparam cmd_code_t CMD_OPEN   = 2'd1;
	localparam cmd_code_t CMD_APPEND = 2'd2;
	localparam cmd_code_t CMD_CHECK  = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_ZERO    = 3'd1;
	localparam status_t ST_UNKNOWN = 3'd2;
	localparam status_t ST_NOEDGE  = 3'd3;
	localparam status_t ST_FULL    = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic    clear;
		logic    open;
		logic    append;
		logic    capture;
		logic    blk_issue;
		logic    edge_start;
		logic    edge_issue;
		logic    finish;
		logic    fin_allowed;
		status_t fin_status;
	} cfi_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic hs_zero;
		logic blk_full;
		logic edge_full;
		logic no_block;
		logic blk_more;
		logic id_hit;
		logic edge_more;
		logic edge_hit;
	} cfi_sts_t;

endpackage

### rtl/cfi_ram.sv
module cfi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/cfi_ctrl.sv
module cfi_ctrl
	import cfi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cmd_code_t command,
	input  cfi_sts_t  sts,
	output cfi_ctl_t  ctl,
	output logic      busy
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_BSCAN = 2'd1;
	localparam logic [1:0] S_ESCAN = 2'd2;

	logic [1:0] state_q, state_d;
	logic       pend_q, pend_d;  // a table read was issued last cycle

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		pend_d  = pend_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (command)
						CMD_CLEAR: begin
							ctl.clear      = 1'b1;
							ctl.finish     = 1'b1;
							ctl.fin_status = ST_OK;
						end
						CMD_OPEN: begin
							ctl.finish = 1'b1;
							if (sts.blk_full) begin
								ctl.fin_status = ST_FULL;
							end else begin
								ctl.open       = 1'b1;
								ctl.fin_status = ST_OK;
							end
						end
						CMD_APPEND: begin
							ctl.finish = 1'b1;
							if (sts.no_block) begin
								ctl.fin_status = ST_UNKNOWN;
							end else if (sts.edge_full) begin
								ctl.fin_status = ST_FULL;
							end else begin
								ctl.append     = 1'b1;
								ctl.fin_status = ST_OK;
							end
						end
						CMD_CHECK: begin
							if (sts.hs_zero) begin
								ctl.finish     = 1'b1;
								ctl.fin_status = ST_ZERO;
							end else begin
								ctl.capture = 1'b1;
								pend_d      = 1'b0;
								state_d     = S_BSCAN;
							end
						end
						default: ;
					endcase
				end
			end
			S_BSCAN: begin
				if (pend_q && sts.id_hit) begin
					ctl.edge_start = 1'b1;
					pend_d         = 1'b0;
					state_d        = S_ESCAN;
				end else if (sts.blk_more) begin
					ctl.blk_issue = 1'b1;
					pend_d        = 1'b1;
				end else begin
					ctl.finish     = 1'b1;
					ctl.fin_status = ST_UNKNOWN;
					state_d        = S_IDLE;
				end
			end
			S_ESCAN: begin
				if (pend_q && sts.edge_hit) begin
					ctl.finish      = 1'b1;
					ctl.fin_allowed = 1'b1;
					ctl.fin_status  = ST_OK;
					state_d         = S_IDLE;
				end else if (sts.edge_more) begin
					ctl.edge_issue = 1'b1;
					pend_d         = 1'b1;
				end else begin
					ctl.finish     = 1'b1;
					ctl.fin_status = ST_NOEDGE;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

endmodule

### rtl/cfi_dp.sv
module cfi_dp
	import cfi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] hotsite,
	input  logic [31:0] address,
	input  logic        cfg_valid,
	input  logic [31:0] cfg_data,
	input  cfi_ctl_t    ctl,
	output cfi_sts_t    sts,
	output logic        done,
	output logic        allowed,
	output logic [2:0]  status
);

	logic [31:0]        offset_q;
	logic [BCNT_W-1:0]  blocks_used_q;
	logic [ECNT_W-1:0]  edges_used_q;
	logic [31:0]        open_id_q;
	logic [EDGE_AW-1:0] open_first_q;
	logic [ECNT_W-1:0]  open_total_q;
	logic [31:0]        hs_q;
	logic [31:0]        tgt_q;
	logic [BCNT_W-1:0]  bidx_q;
	logic [ECNT_W-1:0]  eidx_q;
	logic [ECNT_W-1:0]  ecnt_q;
	logic               done_q;
	logic               allowed_q;
	status_t            status_q;

	logic [BLK_W-1:0]   blk_wdata, blk_rdata;
	logic [BCNT_W-1:0]  blk_last;
	logic [BLK_AW-1:0]  blk_waddr;
	logic [31:0]        edge_rdata;
	logic [31:0]        rd_id;
	logic [EDGE_AW-1:0] rd_first;
	logic [ECNT_W-1:0]  rd_total;

	assign blk_last  = blocks_used_q - BCNT_W'(1);
	assign blk_waddr = ctl.open ? blocks_used_q[BLK_AW-1:0] : blk_last[BLK_AW-1:0];
	assign blk_wdata = ctl.open ? {hotsite, edges_used_q[EDGE_AW-1:0], ECNT_W'(0)}
	                            : {open_id_q, open_first_q, open_total_q + ECNT_W'(1)};

	assign rd_id    = blk_rdata[BLK_W-1 -: 32];
	assign rd_first = blk_rdata[ECNT_W +: EDGE_AW];
	assign rd_total = blk_rdata[ECNT_W-1:0];

	cfi_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_blk_ram (
		.clk   (clk),
		.we    (ctl.open | ctl.append),
		.waddr (blk_waddr),
		.wdata (blk_wdata),
		.re    (ctl.blk_issue),
		.raddr (bidx_q[BLK_AW-1:0]),
		.rdata (blk_rdata)
	);

	cfi_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (ctl.append),
		.waddr (edges_used_q[EDGE_AW-1:0]),
		.wdata (address),
		.re    (ctl.edge_issue),
		.raddr (eidx_q[EDGE_AW-1:0]),
		.rdata (edge_rdata)
	);

	always_comb begin
		sts.hs_zero   = (hotsite == 32'd0);
		sts.blk_full  = (blocks_used_q == BCNT_W'(MAX_BLOCKS));
		sts.edge_full = (edges_used_q == ECNT_W'(MAX_EDGES));
		sts.no_block  = (blocks_used_q == '0);
		sts.blk_more  = (bidx_q < blocks_used_q);
		sts.id_hit    = (rd_id == hs_q);
		sts.edge_more = (ecnt_q != '0) && (eidx_q < ECNT_W'(MAX_EDGES));
		sts.edge_hit  = ((edge_rdata - offset_q) == tgt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q      <= '0;
			blocks_used_q <= '0;
			edges_used_q  <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= ctl.finish;
			if (cfg_valid) begin
				offset_q <= cfg_data;
			end
			if (ctl.clear) begin
				blocks_used_q <= '0;
				edges_used_q  <= '0;
			end
			if (ctl.open) begin
				blocks_used_q <= blocks_used_q + BCNT_W'(1);
			end
			if (ctl.append) begin
				edges_used_q <= edges_used_q + ECNT_W'(1);
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.open) begin
			open_id_q    <= hotsite;
			open_first_q <= edges_used_q[EDGE_AW-1:0];
			open_total_q <= '0;
		end
		if (ctl.append) begin
			open_total_q <= open_total_q + ECNT_W'(1);
		end
		if (ctl.capture) begin
			hs_q   <= hotsite;
			tgt_q  <= address;
			bidx_q <= '0;
		end
		if (ctl.blk_issue) begin
			bidx_q <= bidx_q + BCNT_W'(1);
		end
		if (ctl.edge_start) begin
			eidx_q <= ECNT_W'(rd_first);
			ecnt_q <= rd_total;
		end
		if (ctl.edge_issue) begin
			eidx_q <= eidx_q + ECNT_W'(1);
			ecnt_q <= ecnt_q - ECNT_W'(1);
		end
		if (ctl.finish) begin
			allowed_q <= ctl.fin_allowed;
			status_q  <= ctl.fin_status;
		end
	end

	assign done    = done_q;
	assign allowed = allowed_q;
	assign status  = status_q;

endmodule

### rtl/cfi_jump_edge_checker_top.sv
// Control-flow edge checker. Commands come in on start/command/hotsite/address and are
// taken at a clock edge with start high and busy low; each transaction gives exactly one
// result, shown on done/allowed/status for a single cycle. The receiver cannot stall:
// sample the result in the cycle done is high or it is gone. Clear, open-block,
// append-edge and a check of hotsite zero finish on accept, with the result in the
// next cycle and busy never raised, so these may be issued every cycle. A check of a
// nonzero hotsite raises busy while it walks the block table one entry per cycle and
// then the matching block's edge list one edge per cycle, both through the registered
// read port of an on-chip RAM. The address offset is written through cfg_valid/cfg_data
// (cfg_ready is always high) and should only be changed while no transaction is pending.
// The table RAMs need no clearing after reset: only entries below the fill counts are read.
module cfi_jump_edge_checker_top
	import cfi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command transaction
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] hotsite,
	input  logic [31:0] address,
	// offset register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// result strobe
	output logic        done,
	output logic        allowed,
	output logic [2:0]  status
);

	cfi_ctl_t ctl;
	cfi_sts_t sts;

	// offset write always accepted
	assign cfg_ready = 1'b1;

	// sequencer: decodes commands, drives table walks
	cfi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	// table RAMs, fill counters, compare logic and result register
	cfi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.hotsite   (hotsite),
		.address   (address),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.done      (done),
		.allowed   (allowed),
		.status    (status)
	);

endmodule

### rtl/cfi_checker.sv
module cfi_checker
	import cfi_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        allowed,
	input logic [2:0]  status
);

	// accepted transaction either completes next cycle or holds the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction neither finished nor went busy");

	// a result never shows while a check is still walking the table
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && busy))
		else $error("result strobe while busy");

	// end of a check always delivers its result
	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// allowed only with a clean match
	a_allowed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && allowed) |-> (status == ST_OK))
		else $error("allowed with nonzero status");

endmodule

bind cfi_jump_edge_checker_top cfi_checker u_cfi_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import cfi_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = CMD_CLEAR;
	logic [31:0] hotsite = '0;
	logic [31:0] address = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        done;
	logic        allowed;
	logic [2:0]  status;

	cfi_jump_edge_checker_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.hotsite   (hotsite),
		.address   (address),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.allowed   (allowed),
		.status    (status)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop, set well past the slowest legal run.
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Graph table mirror: same capacities and counter widths as the block
	// ------------------------------------------------------------------
	logic [31:0]        gt_blk_id    [MAX_BLOCKS];
	logic [EDGE_AW-1:0] gt_blk_first [MAX_BLOCKS];
	logic [ECNT_W-1:0]  gt_blk_total [MAX_BLOCKS];
	logic [31:0]        gt_edge_addr [MAX_EDGES];
	logic [BCNT_W-1:0]  gt_blk_used  = '0;
	logic [ECNT_W-1:0]  gt_edge_used = '0;
	logic [31:0]        gt_offset    = '0;

	// Apply one command to the mirror and return the verdict it should produce.
	function automatic void graph_step(input cmd_code_t c, input logic [31:0] h,
			input logic [31:0] a, output logic alw, output status_t st);
		int   b;
		int   k;
		int   sel;
		logic [31:0] rebased;
		alw = 1'b0;
		st  = ST_OK;
		sel = -1;
		case (c)
		CMD_CLEAR: begin
			gt_blk_used  = '0;
			gt_edge_used = '0;
		end
		CMD_OPEN: begin
			if (gt_blk_used >= MAX_BLOCKS) begin
				st = ST_FULL;
			end else begin
				gt_blk_id[gt_blk_used]    = h;
				gt_blk_first[gt_blk_used] = gt_edge_used[EDGE_AW-1:0];
				gt_blk_total[gt_blk_used] = '0;
				gt_blk_used = gt_blk_used + 1'b1;
			end
		end
		CMD_APPEND: begin
			if (gt_blk_used == 0) begin
				st = ST_UNKNOWN;
			end else if (gt_edge_used >= MAX_EDGES) begin
				st = ST_FULL;
			end else begin
				gt_edge_addr[gt_edge_used] = a;
				gt_blk_total[gt_blk_used - 1] = gt_blk_total[gt_blk_used - 1] + 1'b1;
				gt_edge_used = gt_edge_used + 1'b1;
			end
		end
		default: begin
			if (h == 32'd0) begin
				st = ST_ZERO;
			end else begin
				// first block with this id wins, later duplicates are shadowed
				for (b = 0; b < gt_blk_used && sel < 0; b++)
					if (gt_blk_id[b] == h)
						sel = b;
				if (sel < 0) begin
					st = ST_UNKNOWN;
				end else begin
					st = ST_NOEDGE;
					for (k = 0; k < gt_blk_total[sel]; k++) begin
						rebased = gt_edge_addr[gt_blk_first[sel] + k] - gt_offset;
						if (rebased == a) begin
							alw = 1'b1;
							st  = ST_OK;
						end
					end
				end
			end
		end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Verdict scoreboard
	// ------------------------------------------------------------------
	typedef struct packed {
		logic    alw;
		status_t st;
	} verdict_t;

	verdict_t verdict_q[$];
	int       fault_cnt = 0;

	// Directed rows may carry a hand-typed verdict alongside the command.
	logic    row_typed = 1'b0;
	logic    row_alw = 1'b0;
	status_t row_st = ST_OK;

	always @(posedge clk) begin : score
		logic     p_alw;
		status_t  p_st;
		verdict_t want;
		if (cfg_valid && cfg_ready)
			gt_offset = cfg_data;
		if (start && !busy) begin
			graph_step(command, hotsite, address, p_alw, p_st);
			if (row_typed) begin
				p_alw = row_alw;
				p_st  = row_st;
			end
			verdict_q.push_back('{alw: p_alw, st: p_st});
		end
		if (done) begin
			if (verdict_q.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= 10)
					$display("%0t: result with no transaction pending: allowed=%0b status=%0d",
						$realtime, allowed, status);
			end else begin
				want = verdict_q.pop_front();
				if (allowed !== want.alw || status !== want.st) begin
					fault_cnt++;
					if (fault_cnt <= 10)
						$display("%0t: mismatch: expected allowed=%0b status=%0d, got allowed=%0b status=%0d",
							$realtime, want.alw, want.st, allowed, status);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Command driver
	// ------------------------------------------------------------------
	bit calm = 1'b0;  // no idle cycles while set
	int item_cnt = 0;

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Present one transaction and hold it until busy is low at a rising edge.
	// start stays high on return so the next call can go back-to-back.
	task automatic issue(input cmd_code_t c, input logic [31:0] h, input logic [31:0] a,
			input logic typed, input logic alw, input status_t st);
		int gap;
		gap = idle_len();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		command   <= c;
		hotsite   <= h;
		address   <= a;
		row_typed <= typed;
		row_alw   <= alw;
		row_st    <= st;
		do @(posedge clk); while (busy);
		item_cnt++;
	endtask

	// Stop sending and wait until every pending verdict has been checked.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	logic [31:0] offset_now = '0;

	task automatic set_offset(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		offset_now = v;
	endtask

	// ------------------------------------------------------------------
	// Directed rows: reset offset (0), so hits need edge == target
	// ------------------------------------------------------------------
	typedef struct packed {
		cmd_code_t   cmd;
		logic [31:0] hs;
		logic [31:0] addr;
		logic        typed;
		logic        alw;
		status_t     st;
	} row_t;

	localparam int N_ROWS = 23;
	row_t dir_rows [N_ROWS];

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int          i;
		int          j;
		int          ph;
		int          n_blk;
		int          n_edge;
		int          n_chk;
		int          r;
		logic [31:0] id;
		logic [31:0] tgt;
		logic [31:0] far_edge;
		logic [31:0] last_id;
		logic [31:0] phase_ofs [4];
		logic [31:0] id_pool[$];
		logic [31:0] edge_pool[$];

		dir_rows = '{
			// append with no block open yet
			'{CMD_APPEND, 32'h0000_0000, 32'h0000_1234, 1'b1, 1'b0, ST_UNKNOWN},
			'{CMD_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, ST_ZERO},
			'{CMD_CHECK,  32'h0000_0005, 32'h0000_0000, 1'b1, 1'b0, ST_UNKNOWN},
			'{CMD_OPEN,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, ST_OK},
			// block present but holds no edges
			'{CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, ST_NOEDGE},
			'{CMD_APPEND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK},
			'{CMD_APPEND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, ST_OK},
			'{CMD_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_OK},
			'{CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, ST_OK},
			'{CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, ST_NOEDGE},
			// id zero may be opened but can never match
			'{CMD_OPEN,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK},
			'{CMD_APPEND, 32'h0000_0000, 32'hA5A5_5A5A, 1'b1, 1'b0, ST_OK},
			'{CMD_CHECK,  32'h0000_0000, 32'hA5A5_5A5A, 1'b1, 1'b0, ST_ZERO},
			// duplicate id: only the first block is searched
			'{CMD_OPEN,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, ST_OK},
			'{CMD_APPEND, 32'h1234_5678, 32'h1357_9BDF, 1'b1, 1'b0, ST_OK},
			'{CMD_CHECK,  32'hFFFF_FFFF, 32'h1357_9BDF, 1'b1, 1'b0, ST_NOEDGE},
			'{CMD_OPEN,   32'h8000_0001, 32'h5555_5555, 1'b0, 1'b0, ST_OK},
			'{CMD_APPEND, 32'hAAAA_AAAA, 32'h7FFF_FFFE, 1'b0, 1'b0, ST_OK},
			'{CMD_CHECK,  32'h8000_0001, 32'h7FFF_FFFE, 1'b0, 1'b0, ST_OK},
			'{CMD_CHECK,  32'h8000_0002, 32'h7FFF_FFFE, 1'b1, 1'b0, ST_UNKNOWN},
			// clear ignores its fields
			'{CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK},
			'{CMD_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_UNKNOWN},
			'{CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_UNKNOWN}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed rows ---
		for (i = 0; i < N_ROWS; i++)
			issue(dir_rows[i].cmd, dir_rows[i].hs, dir_rows[i].addr,
				dir_rows[i].typed, dir_rows[i].alw, dir_rows[i].st);
		drain();

		// --- fill both stores past capacity, offset at its top value ---
		set_offset(32'hFFFF_FFFF);
		issue(CMD_CLEAR, $urandom, $urandom, 1'b0, 1'b0, ST_OK);
		issue(CMD_OPEN, 32'hC0DE_0001, $urandom, 1'b0, 1'b0, ST_OK);
		far_edge = '0;
		// one block takes the whole edge store; the last append overflows
		for (i = 0; i <= MAX_EDGES; i++) begin
			tgt = $urandom;
			if (i == MAX_EDGES - 1)
				far_edge = tgt;
			issue(CMD_APPEND, $urandom, tgt, 1'b0, 1'b0, ST_OK);
		end
		// remaining blocks, last open overflows
		last_id = '0;
		for (i = 1; i <= MAX_BLOCKS; i++) begin
			id = $urandom | 32'h1;
			if (i == MAX_BLOCKS - 1)
				last_id = id;
			issue(CMD_OPEN, id, $urandom, 1'b0, 1'b0, ST_OK);
		end
		// hit on the very last stored edge; wrapping subtract of the offset
		issue(CMD_CHECK, 32'hC0DE_0001, far_edge - offset_now, 1'b0, 1'b0, ST_OK);
		issue(CMD_CHECK, 32'hC0DE_0001, $urandom, 1'b0, 1'b0, ST_OK);
		issue(CMD_CHECK, last_id, $urandom, 1'b0, 1'b0, ST_OK);
		issue(CMD_CHECK, 32'hC0DE_0002, $urandom, 1'b0, 1'b0, ST_OK);
		issue(CMD_APPEND, $urandom, $urandom, 1'b0, 1'b0, ST_OK);
		issue(CMD_OPEN, $urandom, $urandom, 1'b0, 1'b0, ST_OK);
		drain();

		// --- random part, four offset settings ---
		phase_ofs[0] = $urandom;
		phase_ofs[1] = 32'h0000_0000;
		phase_ofs[2] = 32'h8000_0000;
		phase_ofs[3] = $urandom;
		item_cnt = 0;
		for (ph = 0; ph < 4; ph++) begin
			drain();
			set_offset(phase_ofs[ph]);
			while (item_cnt < (ph + 1) * 100) begin
				calm = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 15) begin
					// noise: anything at all
					n_chk = $urandom_range(1, 4);
					for (j = 0; j < n_chk; j++)
						issue(cmd_code_t'($urandom_range(0, 3)), $urandom, $urandom,
							1'b0, 1'b0, ST_OK);
				end else begin
					// build a small graph, then probe it; sometimes keep the old table
					if ($urandom_range(0, 4) != 0 || id_pool.size() > 24) begin
						issue(CMD_CLEAR, $urandom, $urandom, 1'b0, 1'b0, ST_OK);
						id_pool.delete();
						edge_pool.delete();
					end
					n_blk = $urandom_range(1, 5);
					for (i = 0; i < n_blk; i++) begin
						r = $urandom_range(0, 99);
						if (r < 10)
							id = '0;
						else if (r < 30 && id_pool.size() != 0)
							id = id_pool[$urandom_range(0, id_pool.size() - 1)];
						else
							id = $urandom;
						issue(CMD_OPEN, id, $urandom, 1'b0, 1'b0, ST_OK);
						id_pool.push_back(id);
						n_edge = $urandom_range(0, 4);
						for (j = 0; j < n_edge; j++) begin
							tgt = $urandom;
							issue(CMD_APPEND, $urandom, tgt, 1'b0, 1'b0, ST_OK);
							edge_pool.push_back(tgt);
						end
					end
					n_chk = $urandom_range(2, 6);
					for (i = 0; i < n_chk; i++) begin
						r = $urandom_range(0, 99);
						if (r < 65)
							id = id_pool[$urandom_range(0, id_pool.size() - 1)];
						else if (r < 75)
							id = '0;
						else
							id = $urandom;
						if ($urandom_range(0, 99) < 60 && edge_pool.size() != 0)
							tgt = edge_pool[$urandom_range(0, edge_pool.size() - 1)]
								- offset_now;
						else
							tgt = $urandom;
						issue(CMD_CHECK, id, tgt, 1'b0, 1'b0, ST_OK);
					end
					// occasionally hold off until everything is back
					if ($urandom_range(0, 19) == 0)
						drain();
				end
			end
		end

		drain();
		if (fault_cnt == 0 && verdict_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
